// File: design/gta_pkg.sv
`timescale 1ns / 1ps
// gta_pkg: shared types and constants for the fixed-point matrix multiply block
// no dependencies; imported by gta_mac and the top level

package gta_pkg;

   // request commands
   typedef enum logic [2:0] {
      CMD_WRITE_A = 3'd0,
      CMD_WRITE_B = 3'd1,
      CMD_WRITE_C = 3'd2,
      CMD_COMPUTE = 3'd3,
      CMD_READ_C  = 3'd4
   } cmd_type;

   // register indexes of the csr port
   localparam logic [2:0] CSR_TRANS_A = 3'd0;
   localparam logic [2:0] CSR_TRANS_B = 3'd1;
   localparam logic [2:0] CSR_ROWS_M  = 3'd2;
   localparam logic [2:0] CSR_COLS_N  = 3'd3;
   localparam logic [2:0] CSR_DEPTH_K = 3'd4;
   localparam logic [2:0] CSR_ALPHA   = 3'd5;
   localparam logic [2:0] CSR_BETA    = 3'd6;

   // result kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // element format and scaling
   localparam int ELEM_W     = 16;
   localparam int PROD_W     = 32;
   localparam int FRAC_SHIFT = 20;
   localparam int ROUND_BIT  = 19;
   localparam int BETA_ALIGN = 8;
   localparam int SAT_MAX    = 32767;
   localparam int SAT_MIN    = -32768;
   localparam logic [ELEM_W-1:0] ELEM_MAX = 16'h7fff;
   localparam logic [ELEM_W-1:0] ELEM_MIN = 16'h8000;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // tag that follows one multiply-accumulate step down the pipeline
   typedef struct packed {
      logic valid;
      logic first_k;
      logic last_k;
      logic zero_k;
      logic last_elem;
   } issue_type;

   // end of a compute
   typedef struct packed {
      logic valid;
      logic overflow;
   } done_type;

endpackage

// File: design/gta_mem.sv
`timescale 1ns / 1ps
// gta_mem: single write port, single read port synchronous ram
// read data registered, read-first; no dependencies

module gta_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/gta_mac.sv
`timescale 1ns / 1ps
// gta_mac: multiply-accumulate, alpha/beta scaling, rounding and saturation
// depends on gta_pkg; fed by the a, b and c ram read ports

module gta_mac
   import gta_pkg::*;
#(
   parameter int ACC_W = 36,
   parameter int AW    = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  issue_type                issue,
   input  logic [AW-1:0]            issue_addr,
   input  logic [ELEM_W-1:0]        a_data,
   input  logic [ELEM_W-1:0]        b_data,
   input  logic [ELEM_W-1:0]        c_data,
   input  logic signed [ELEM_W-1:0] alpha,
   input  logic signed [ELEM_W-1:0] beta,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [ELEM_W-1:0]        wr_data,
   output done_type                 done
);

   localparam int SA_W  = ACC_W + ELEM_W;
   localparam int TOT_W = SA_W + 1;
   localparam int Q_W   = TOT_W - FRAC_SHIFT;
   localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(SAT_MAX);
   localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(SAT_MIN);
   localparam logic signed [TOT_W-1:0] ROUND = TOT_W'(1) <<< ROUND_BIT;

   issue_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag4_in;
   logic [AW-1:0] addr1_ff, addr2_ff, addr3_ff, addr4_ff;

   logic signed [PROD_W-1:0] mult;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [ELEM_W-1:0]        c1_ff, c2_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [SA_W-1:0]   sa_ff, sa_in;
   logic signed [PROD_W-1:0] sb_ff, sb_in;
   logic                     flag_ff;

   logic signed [TOT_W-1:0] sa_ext, sb_ext, total;
   logic signed [Q_W-1:0]   q;
   logic                    sat_hi, sat_lo;

   // signed 16x16 product
   assign mult = $signed(a_data) * $signed(b_data);

   // products masked when the inner dimension is empty
   assign prod_in = tag1_ff.zero_k ? '0 : mult;
   assign acc_in  = (tag2_ff.first_k ? '0 : acc_ff) + ACC_W'(prod_ff);
   assign sa_in   = alpha * acc_ff;
   assign sb_in   = beta * $signed(c2_ff);

   always_comb begin
      tag4_in       = tag3_ff;
      tag4_in.valid = tag3_ff.valid & tag3_ff.last_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         flag_ff <= 1'b0;
      end else begin
         tag1_ff <= issue;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag4_in;
         if (done.valid) begin
            flag_ff <= 1'b0;
         end else if (tag4_ff.valid && (sat_hi || sat_lo)) begin
            flag_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff <= issue_addr;
      addr2_ff <= addr1_ff;
      addr3_ff <= addr2_ff;
      prod_ff  <= prod_in;
      // old c only matters with nonzero beta
      if (tag1_ff.valid && tag1_ff.last_k) begin
         c1_ff <= (beta == '0) ? '0 : c_data;
      end
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (tag2_ff.valid && tag2_ff.last_k) begin
         c2_ff <= c1_ff;
      end
      if (tag4_in.valid) begin
         sa_ff    <= sa_in;
         sb_ff    <= sb_in;
         addr4_ff <= addr3_ff;
      end
   end

   // round to nearest, ties up, then saturate
   assign sa_ext = TOT_W'(sa_ff);
   assign sb_ext = TOT_W'(sb_ff);
   assign total  = sa_ext + (sb_ext <<< BETA_ALIGN) + ROUND;
   assign q      = total[TOT_W-1:FRAC_SHIFT];
   assign sat_hi = q > Q_MAX;
   assign sat_lo = q < Q_MIN;

   assign wr_en   = tag4_ff.valid;
   assign wr_addr = addr4_ff;
   assign wr_data = sat_hi ? ELEM_MAX : (sat_lo ? ELEM_MIN : q[ELEM_W-1:0]);

   assign done.valid    = tag4_ff.valid & tag4_ff.last_elem;
   assign done.overflow = flag_ff | sat_hi | sat_lo;

endmodule

// File: design/gemm_transpose_alpha_beta.sv
`timescale 1ns / 1ps
// gemm_transpose_alpha_beta: top level, csr registers, command decode and compute sequencer
// depends on gta_pkg, gta_mem and gta_mac

// Fixed-point GEMM, C := beta*C + alpha*op(A)*op(B), on three MAX_DIM by MAX_DIM
// stores of Q8.8 elements held in single-port-write synchronous rams. A request is
// taken when start is high and busy is low. Element writes give no result. A read
// of C gives its result on the rsp_ ports through the pend_ and then the rsp_
// registers, and reads may follow each other every cycle while busy is low. A compute
// walks the used corner of C one multiply-accumulate per cycle through one shared
// 16x16 multiplier fed from the A and B rams, and the finish result appears in the
// first cycle with busy low. A compute with zero rows or columns writes nothing and
// reports like a read, through the same registers. The rsp_valid strobe lasts one
// cycle and the receiver cannot hold it off, so results must be taken as they come.
// Csr registers are to be written only while the block is idle, by the user; the
// block itself does not enforce this.

module gemm_transpose_alpha_beta
   import gta_pkg::*;
#(
   parameter int MAX_DIM = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_command,
   input  logic [3:0]               req_row_index,
   input  logic [3:0]               req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   // result channel
   output logic                     rsp_valid,
   output logic                     rsp_result_kind,
   output logic signed [ELEM_W-1:0] rsp_read_value,
   output logic                     rsp_overflow_flag,
   // csr write port
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_index,
   input  logic [ELEM_W-1:0]        csr_write_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int CMP_W = $clog2(MAX_DIM + 1) + 5;
   localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
   localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

   // csr registers
   logic              trans_a_ff, trans_b_ff;
   logic [4:0]        rows_m_ff, cols_n_ff, depth_k_ff;
   logic [ELEM_W-1:0] alpha_ff, beta_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   issue_type        issue;

   // pending read or empty compute result
   logic pend_valid_ff, pend_kind_ff, pend_inside_ff;

   // result registers
   logic              rsp_valid_ff, rsp_kind_ff, rsp_flag_ff;
   logic [ELEM_W-1:0] rsp_value_ff;

   logic                    accept, req_inside, empty_compute;
   logic [AW+3:0]           req_addr_wide;
   logic [AW-1:0]           req_addr, a_addr, b_addr, ci_addr;
   logic [CMP_W-1:0]        m_eff, n_eff, k_eff;
   logic                    last_i, last_j, last_k;
   logic [ELEM_W-1:0]       a_q, b_q, c_q;
   logic                    a_we, b_we, c_we;
   logic [AW-1:0]           c_wr_addr, c_rd_addr;
   logic [ELEM_W-1:0]       c_wr_data;
   logic                    mac_wr_en;
   logic [AW-1:0]           mac_wr_addr;
   logic [ELEM_W-1:0]       mac_wr_data;
   done_type                done;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // request address; rows or columns past the store are dropped
   assign req_inside    = (CMP_W'(req_row_index) < DIM_LIMIT) &&
                          (CMP_W'(req_col_index) < DIM_LIMIT);
   assign req_addr_wide = (AW+4)'(req_row_index) * (AW+4)'(MAX_DIM) +
                          (AW+4)'(req_col_index);
   assign req_addr      = req_addr_wide[AW-1:0];

   // dimensions above the store size are clipped
   assign m_eff = (CMP_W'(rows_m_ff) > DIM_LIMIT)  ? DIM_LIMIT : CMP_W'(rows_m_ff);
   assign n_eff = (CMP_W'(cols_n_ff) > DIM_LIMIT)  ? DIM_LIMIT : CMP_W'(cols_n_ff);
   assign k_eff = (CMP_W'(depth_k_ff) > DIM_LIMIT) ? DIM_LIMIT : CMP_W'(depth_k_ff);

   assign empty_compute = (m_eff == '0) || (n_eff == '0);

   // csr writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         trans_a_ff <= 1'b0;
         trans_b_ff <= 1'b0;
         rows_m_ff  <= 5'd16;
         cols_n_ff  <= 5'd16;
         depth_k_ff <= 5'd16;
         alpha_ff   <= 16'h1000;
         beta_ff    <= 16'h0000;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TRANS_A: trans_a_ff <= csr_write_data[0];
            CSR_TRANS_B: trans_b_ff <= csr_write_data[0];
            CSR_ROWS_M:  rows_m_ff  <= csr_write_data[4:0];
            CSR_COLS_N:  cols_n_ff  <= csr_write_data[4:0];
            CSR_DEPTH_K: depth_k_ff <= csr_write_data[4:0];
            CSR_ALPHA:   alpha_ff   <= csr_write_data;
            CSR_BETA:    beta_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // loop position: k innermost, then column j, then row i
   assign last_k = (CMP_W'(k_ff) + CMP_W'(1)) >= k_eff;
   assign last_j = (CMP_W'(j_ff) + CMP_W'(1)) >= n_eff;
   assign last_i = (CMP_W'(i_ff) + CMP_W'(1)) >= m_eff;

   // op(A)(i,k) and op(B)(k,j) addresses, C entry of the current element
   assign a_addr  = trans_a_ff ? AW'(k_ff) * AW'(MAX_DIM) + AW'(i_ff)
                               : AW'(i_ff) * AW'(MAX_DIM) + AW'(k_ff);
   assign b_addr  = trans_b_ff ? AW'(j_ff) * AW'(MAX_DIM) + AW'(k_ff)
                               : AW'(k_ff) * AW'(MAX_DIM) + AW'(j_ff);
   assign ci_addr = AW'(i_ff) * AW'(MAX_DIM) + AW'(j_ff);

   always_comb begin
      state_in        = state_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      issue           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (accept && (req_command == CMD_COMPUTE) && !empty_compute) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            issue.valid     = 1'b1;
            issue.first_k   = (k_ff == '0);
            issue.last_k    = last_k;
            issue.zero_k    = (k_eff == '0);
            issue.last_elem = last_k & last_j & last_i;
            if (!last_k) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!last_j) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  if (!last_i) begin
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // wait for the last element to leave the pipeline
            if (done.valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // ram write and read selection
   assign a_we = accept && (req_command == CMD_WRITE_A) && req_inside;
   assign b_we = accept && (req_command == CMD_WRITE_B) && req_inside;

   // c is written back by the pipeline while busy, by requests otherwise
   assign c_we      = busy ? mac_wr_en : (accept && (req_command == CMD_WRITE_C) && req_inside);
   assign c_wr_addr = busy ? mac_wr_addr : req_addr;
   assign c_wr_data = busy ? mac_wr_data : req_element_value;
   assign c_rd_addr = (state_ff == ST_RUN) ? ci_addr : req_addr;

   gta_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (ELEM_W)
   ) u_mem_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (req_addr),
      .wr_data (req_element_value),
      .rd_addr (a_addr),
      .rd_data (a_q)
   );

   gta_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (ELEM_W)
   ) u_mem_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (req_addr),
      .wr_data (req_element_value),
      .rd_addr (b_addr),
      .rd_data (b_q)
   );

   gta_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (ELEM_W)
   ) u_mem_c (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_rd_addr),
      .rd_data (c_q)
   );

   gta_mac #(
      .ACC_W (ACC_W),
      .AW    (AW)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_addr (ci_addr),
      .a_data     (a_q),
      .b_data     (b_q),
      .c_data     (c_q),
      .alpha      ($signed(alpha_ff)),
      .beta       ($signed(beta_ff)),
      .wr_en      (mac_wr_en),
      .wr_addr    (mac_wr_addr),
      .wr_data    (mac_wr_data),
      .done       (done)
   );

   // reads and empty computes are held in the pend_ registers for the c ram output
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= accept && ((req_command == CMD_READ_C) ||
                          ((req_command == CMD_COMPUTE) && empty_compute));
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff   <= (req_command == CMD_COMPUTE) ? KIND_DONE : KIND_READ;
      pend_inside_ff <= req_inside;
   end

   // result register, one cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid | pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      priority if (done.valid) begin
         rsp_kind_ff  <= KIND_DONE;
         rsp_value_ff <= '0;
         rsp_flag_ff  <= done.overflow;
      end else if (pend_valid_ff) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_value_ff <= ((pend_kind_ff == KIND_READ) && pend_inside_ff) ? c_q : '0;
         rsp_flag_ff  <= 1'b0;
      end else begin
         rsp_kind_ff  <= rsp_kind_ff;
         rsp_value_ff <= rsp_value_ff;
         rsp_flag_ff  <= rsp_flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_read_value    = $signed(rsp_value_ff);
   assign rsp_overflow_flag = rsp_flag_ff;

endmodule
